// ===== hw/rtl/radix_digit_emitter_defines.svh =====
// Assertion macros shared by the radix digit emitter RTL.
// Included by files that carry concurrent assertions; no dependencies.
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// Same-cycle implication.
`define RDE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rde assertion failed");

// Next-cycle implication.
`define RDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rde assertion failed");

`endif

// ===== hw/rtl/rde_pkg.sv =====
// Shared types, command codes and constants of the radix digit emitter.
// No dependencies.
package rde_pkg;

   localparam int NUM_W  = 32;
   localparam int CHAR_W = 8;
   localparam int CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONVERT = 2'd2;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam logic [CHAR_W-1:0] SYM_MIN   = 8'd32;
   localparam logic [CHAR_W-1:0] SYM_MAX   = 8'd126;
   localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] symbol;
      logic [NUM_W-1:0]  number;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              status;
      logic              last;
   } rsp_payload_type;

   function automatic logic symbol_allowed(input logic [CHAR_W-1:0] sym);
      symbol_allowed = (sym >= SYM_MIN) && (sym <= SYM_MAX) &&
                       (sym != SYM_PLUS) && (sym != SYM_MINUS);
   endfunction

endpackage

// ===== hw/rtl/rde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rde_divider.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on rde_pkg.
module rde_divider
   import rde_pkg::*;
#(
   parameter int DIVISOR_W = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [NUM_W-1:0]     quotient,
   output logic [DIVISOR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;
   logic [DIVISOR_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      fits   = trial >= {1'b0, divisor};
      diff   = trial - {1'b0, divisor};
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNT_W'(NUM_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - CNT_W'(1);
         done_ff <= (cnt_ff == CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/radix_digit_emitter.sv =====
// Radix digit emitter top level: alphabet loading and number-to-digits conversion.
// Depends on rde_pkg, rde_ram, rde_divider and radix_digit_emitter_defines.svh.
//
// A clear transaction zeroes the seen-character map with a pass over every
// entry, one entry per cycle; the same pass runs after reset, so req_ready
// first rises once that pass ends. When the alphabet is not full, an append
// reads the seen map as the transaction is accepted and updates it in the
// next cycle. A convert transaction with a usable alphabet runs the single
// bit-serial divider once per digit, then passes each character through the
// ST_POP, ST_STK and ST_EMIT states to read the digit stack and the alphabet
// RAM. The block takes no new transaction while a clear pass, an append or a
// conversion is running. Each digit comes out as one response, most
// significant first, with last set on the final one; an unusable alphabet
// gives one response with status set and no character.
`include "radix_digit_emitter_defines.svh"

module radix_digit_emitter
   import rde_pkg::*;
#(
   parameter int MAX_SYMBOLS = 128,
   parameter int MAX_DIGITS  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int LEN_W      = $clog2(MAX_SYMBOLS + 1);
   localparam int AL_W       = $clog2(MAX_SYMBOLS);
   localparam int SA_W       = $clog2(MAX_DIGITS);
   localparam int DEPTH_W    = $clog2(MAX_DIGITS + 1);
   localparam int SEEN_DEPTH = 2**CHAR_W;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_DIV   = 8'b00000010,
      ST_POP   = 8'b00000100,
      ST_STK   = 8'b00001000,
      ST_EMIT  = 8'b00010000,
      ST_INVAL = 8'b00100000,
      ST_WIPE  = 8'b01000000,
      ST_MARK  = 8'b10000000
   } state_type;

   state_type       state_ff, state_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic               bad_ff, bad_in;
   logic [CHAR_W-1:0]  wipe_ff, wipe_in;
   logic [CHAR_W-1:0]  sym_ff, sym_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               rsp_free;
   logic               alpha_full;
   logic               alpha_usable;
   logic               append_bad;
   logic               more_digits;
   logic [DEPTH_W-1:0] depth_dec;
   logic               conv_go;
   logic               rsp_inval;

   logic               div_start;
   logic [NUM_W-1:0]   div_dividend;
   logic               div_done;
   logic [NUM_W-1:0]   div_quotient;
   logic [LEN_W-1:0]   div_remainder;

   logic               alpha_wr_en;
   logic [AL_W-1:0]    alpha_rd_addr;
   logic [CHAR_W-1:0]  alpha_rd_data;
   logic               stk_wr_en;
   logic [AL_W-1:0]    stk_rd_data;
   logic               digit_ok;

   logic               seen_wr_en;
   logic [CHAR_W-1:0]  seen_wr_addr;
   logic               seen_wr_data;
   logic               seen_rd_data;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign alpha_full   = (length_ff == LEN_W'(MAX_SYMBOLS));
   assign alpha_usable = !bad_ff && (length_ff >= LEN_W'(2));
   assign append_bad   = !symbol_allowed(req_data.symbol);
   assign more_digits  = (div_quotient != '0) && (depth_ff < DEPTH_W'(MAX_DIGITS - 1));
   assign depth_dec    = depth_ff - DEPTH_W'(1);
   assign conv_go      = req_fire && req_data.cmd == CMD_CONVERT && alpha_usable;
   assign rsp_inval    = rsp_valid_ff && (rsp_data_ff.status == STATUS_INVALID);

   assign div_start    = conv_go || (state_ff == ST_DIV && div_done && more_digits);
   assign div_dividend = (state_ff == ST_IDLE) ? req_data.number : div_quotient;

   assign alpha_wr_en   = req_fire && req_data.cmd == CMD_APPEND && !alpha_full;
   assign stk_wr_en     = (state_ff == ST_DIV) && div_done;
   assign digit_ok      = LEN_W'(stk_rd_data) < length_ff;
   assign alpha_rd_addr = digit_ok ? stk_rd_data : '0;

   assign seen_wr_en   = (state_ff == ST_WIPE) || (state_ff == ST_MARK);
   assign seen_wr_addr = (state_ff == ST_MARK) ? sym_ff : wipe_ff;
   assign seen_wr_data = (state_ff == ST_MARK);

   rde_divider #(
      .DIVISOR_W (LEN_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (length_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   rde_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_alphabet_ram (
      .clock   (clock),
      .wr_en   (alpha_wr_en),
      .wr_addr (length_ff[AL_W-1:0]),
      .wr_data (req_data.symbol),
      .rd_en   (state_ff == ST_STK),
      .rd_addr (alpha_rd_addr),
      .rd_data (alpha_rd_data)
   );

   rde_ram #(
      .WIDTH (1),
      .DEPTH (SEEN_DEPTH)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_en   (alpha_wr_en),
      .rd_addr (req_data.symbol),
      .rd_data (seen_rd_data)
   );

   rde_ram #(
      .WIDTH (AL_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (depth_ff[SA_W-1:0]),
      .wr_data (div_remainder[AL_W-1:0]),
      .rd_en   (state_ff == ST_POP),
      .rd_addr (depth_dec[SA_W-1:0]),
      .rd_data (stk_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      bad_in       = bad_ff;
      wipe_in      = wipe_ff;
      sym_in       = sym_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     length_in = '0;
                     bad_in    = 1'b0;
                     wipe_in   = '0;
                     state_in  = ST_WIPE;
                  end
                  CMD_APPEND: begin
                     if (alpha_full) begin
                        bad_in = 1'b1;
                     end else begin
                        if (append_bad) begin
                           bad_in = 1'b1;
                        end
                        sym_in    = req_data.symbol;
                        length_in = length_ff + LEN_W'(1);
                        state_in  = ST_MARK;
                     end
                  end
                  CMD_CONVERT: begin
                     depth_in = '0;
                     state_in = alpha_usable ? ST_DIV : ST_INVAL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WIPE: begin
            wipe_in = wipe_ff + CHAR_W'(1);
            if (wipe_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (seen_rd_data) begin
               bad_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               depth_in = depth_ff + DEPTH_W'(1);
               if (!more_digits) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            depth_in = depth_dec;
            state_in = ST_STK;
         end
         ST_STK: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_char = alpha_rd_data;
               rsp_data_in.status   = STATUS_OK;
               rsp_data_in.last     = (depth_ff == '0);
               state_in             = (depth_ff == '0) ? ST_IDLE : ST_POP;
            end
         end
         ST_INVAL: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_char = '0;
               rsp_data_in.status   = STATUS_INVALID;
               rsp_data_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         length_ff    <= '0;
         bad_ff       <= 1'b0;
         wipe_ff      <= '0;
         sym_ff       <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         bad_ff       <= bad_in;
         wipe_ff      <= wipe_in;
         sym_ff       <= sym_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RDE_ASSERT_IMPLY(a_done_only_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `RDE_ASSERT_IMPLY(a_length_bound, clock, reset, 1'b1, length_ff <= LEN_W'(MAX_SYMBOLS))
   `RDE_ASSERT_IMPLY(a_invalid_rsp_empty, clock, reset, rsp_inval, rsp_data_ff.out_char == '0)
   `RDE_ASSERT_IMPLY(a_invalid_rsp_last, clock, reset, rsp_inval, rsp_data_ff.last == 1'b1)
   `RDE_ASSERT_NEXT(a_convert_starts_div, clock, reset, conv_go, state_ff == ST_DIV)

endmodule
